FILE: sv/cmsm_pkg.sv
package cmsm_pkg;

    localparam int SLOTS  = 4;
    localparam int CANDS  = SLOTS + 1;
    localparam int CIW    = 3;                  // candidate / physical entry index
    localparam int CW     = 32;                 // Q16.16 coordinate
    localparam int DW     = CW + 1;             // coordinate difference
    localparam int OPW    = 68;                 // multiplier operand, signed
    localparam int CHUNK  = 17;                 // multiplier bits per cycle
    localparam int NCHUNK = OPW / CHUNK;
    localparam int PW     = 2 * OPW;            // unsigned product
    localparam int AW     = PW + 2;             // signed accumulator
    localparam int THW    = 31;
    localparam int PCW    = 5;
    localparam int IDX_SUM = CANDS * (CANDS - 1) / 2;   // sum of all entry indexes

    localparam logic [THW-1:0]   THR_RESET  = 31'd1311;
    localparam logic [2*THW-1:0] THSQ_RESET = 62'd1718721;   // 1311 squared

    typedef enum logic [1:0] {
        OC_REPLACE = 2'd0,
        OC_INSERT  = 2'd1,
        OC_REDUCE  = 2'd2
    } t_outcome;

    typedef enum logic [3:0] {
        OPD_DX, OPD_DY, OPD_DZ,
        OPD_E1X, OPD_E1Y, OPD_E1Z,
        OPD_E2X, OPD_E2Y, OPD_E2Z,
        OPD_C0, OPD_C1, OPD_C2
    } t_opnd;

    typedef enum logic [2:0] {
        DST_NONE, DST_CR0, DST_CR1, DST_CR2, DST_MET
    } t_dst;

    typedef struct packed {
        t_opnd a;
        t_opnd b;
        logic  clr;     // start from zero instead of accumulator
        logic  sub;     // subtract product
        t_dst  dst;
    } t_mop;

    // program entry points
    localparam logic [PCW-1:0] PC_DIST     = 5'd0;
    localparam logic [PCW-1:0] PC_DIST_END = 5'd2;
    localparam logic [PCW-1:0] PC_AREA     = 5'd3;
    localparam logic [PCW-1:0] PC_AREA_END = 5'd11;
    localparam logic [PCW-1:0] PC_VOL      = 5'd12;
    localparam logic [PCW-1:0] PC_VOL_END  = 5'd20;

    typedef struct packed {
        logic           in_load;
        logic [CIW-1:0] rd_cand;
        logic           ld_diff;
        logic           ld_base;
        logic           ld_e01;
        logic           ld_e02;
        logic           ld_depth;
        logic           take_best;
        logic           mac_go;
        t_mop           mop;
        logic           swap;
        logic           out_load;
        t_outcome       out_kind;
        logic [1:0]     out_idx;
        logic [2:0]     out_cnt;
        logic           out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic mac_done;
        logic met_lt;
        logic met_gt;
        logic le_th;
    } t_dp_sts;

    // squared distance, |e01 x d|^2, |e01 . (e02 x d)|
    function automatic t_mop mop_rom(input logic [PCW-1:0] pc);
        t_mop m;
        m = '{OPD_DX, OPD_DX, 1'b1, 1'b0, DST_NONE};
        unique case (pc)
            5'd0:  m = '{OPD_DX,  OPD_DX, 1'b1, 1'b0, DST_NONE};
            5'd1:  m = '{OPD_DY,  OPD_DY, 1'b0, 1'b0, DST_NONE};
            5'd2:  m = '{OPD_DZ,  OPD_DZ, 1'b0, 1'b0, DST_MET};
            5'd3:  m = '{OPD_E1Y, OPD_DZ, 1'b1, 1'b0, DST_NONE};
            5'd4:  m = '{OPD_E1Z, OPD_DY, 1'b0, 1'b1, DST_CR0};
            5'd5:  m = '{OPD_E1Z, OPD_DX, 1'b1, 1'b0, DST_NONE};
            5'd6:  m = '{OPD_E1X, OPD_DZ, 1'b0, 1'b1, DST_CR1};
            5'd7:  m = '{OPD_E1X, OPD_DY, 1'b1, 1'b0, DST_NONE};
            5'd8:  m = '{OPD_E1Y, OPD_DX, 1'b0, 1'b1, DST_CR2};
            5'd9:  m = '{OPD_C0,  OPD_C0, 1'b1, 1'b0, DST_NONE};
            5'd10: m = '{OPD_C1,  OPD_C1, 1'b0, 1'b0, DST_NONE};
            5'd11: m = '{OPD_C2,  OPD_C2, 1'b0, 1'b0, DST_MET};
            5'd12: m = '{OPD_E2Y, OPD_DZ, 1'b1, 1'b0, DST_NONE};
            5'd13: m = '{OPD_E2Z, OPD_DY, 1'b0, 1'b1, DST_CR0};
            5'd14: m = '{OPD_E2Z, OPD_DX, 1'b1, 1'b0, DST_NONE};
            5'd15: m = '{OPD_E2X, OPD_DZ, 1'b0, 1'b1, DST_CR1};
            5'd16: m = '{OPD_E2X, OPD_DY, 1'b1, 1'b0, DST_NONE};
            5'd17: m = '{OPD_E2Y, OPD_DX, 1'b0, 1'b1, DST_CR2};
            5'd18: m = '{OPD_E1X, OPD_C0, 1'b1, 1'b0, DST_NONE};
            5'd19: m = '{OPD_E1Y, OPD_C1, 1'b0, 1'b0, DST_NONE};
            5'd20: m = '{OPD_E1Z, OPD_C2, 1'b0, 1'b0, DST_MET};
            default: m = '{OPD_DX, OPD_DX, 1'b1, 1'b0, DST_NONE};
        endcase
        return m;
    endfunction

endpackage

FILE: sv/cmsm_mac.sv
module cmsm_mac
    import cmsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic signed [OPW-1:0] i_a,
    input  logic signed [OPW-1:0] i_b,
    input  logic                  i_clr,
    input  logic                  i_sub,
    output logic                  o_done,
    output logic signed [AW-1:0]  o_acc
);

    localparam int CNTW = $clog2(NCHUNK + 1);

    logic [OPW-1:0]        r_amag;
    logic [OPW-1:0]        r_bsh;
    logic                  r_neg;
    logic                  r_clr;
    logic                  r_busy;
    logic                  r_done;
    logic [CNTW-1:0]       r_cnt;
    logic [PW-1:0]         r_prod;
    logic signed [AW-1:0]  r_acc;

    logic [OPW+CHUNK-1:0]  w_pp;
    logic signed [AW-1:0]  w_pext;
    logic signed [AW-1:0]  w_base;

    // one 68x17 partial product per cycle, high chunk of |b| first
    assign w_pp   = r_amag * r_bsh[OPW-1 -: CHUNK];
    assign w_pext = signed'(AW'(r_prod));
    assign w_base = r_clr ? '0 : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNTW'(NCHUNK)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_amag <= OPW'(i_a[OPW-1] ? -i_a : i_a);
            r_bsh  <= OPW'(i_b[OPW-1] ? -i_b : i_b);
            r_neg  <= i_a[OPW-1] ^ i_b[OPW-1] ^ i_sub;
            r_clr  <= i_clr;
            r_prod <= '0;
        end else if (r_busy) begin
            if (r_cnt == CNTW'(NCHUNK)) begin
                r_acc <= r_neg ? (w_base - w_pext) : (w_base + w_pext);
            end else begin
                r_prod <= (r_prod << CHUNK) + PW'(w_pp);
                r_bsh  <= r_bsh << CHUNK;
            end
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

FILE: sv/cmsm_dp.sv
module cmsm_dp
    import cmsm_pkg::*;
#(
    parameter int TAG_BITS = 16,
    parameter int IN_W     = 144,
    parameter int OUT_W    = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IN_W-1:0]   i_in_data,
    input  logic              i_cfg_we,
    input  logic [THW-1:0]    i_cfg_data,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    output logic [OUT_W-1:0]  o_out_data,
    output logic              o_out_last
);

    localparam int NOPD = 12;

    // five physical entries; four are mapped to slots, one is free
    logic signed [CW-1:0]  r_px  [CANDS];
    logic signed [CW-1:0]  r_py  [CANDS];
    logic signed [CW-1:0]  r_pz  [CANDS];
    logic signed [CW-1:0]  r_dep [CANDS];
    logic [TAG_BITS-1:0]   r_tag [CANDS];
    logic [CIW-1:0]        r_map [SLOTS];
    logic [CIW-1:0]        r_free;
    logic [CIW-1:0]        r_nmap [SLOTS-1];

    logic [TAG_BITS-1:0]   r_in_tag;
    logic signed [CW-1:0]  r_base [3];
    logic signed [DW-1:0]  r_d  [3];
    logic signed [DW-1:0]  r_e1 [3];
    logic signed [DW-1:0]  r_e2 [3];
    logic signed [OPW-1:0] r_cr [3];
    logic [AW-1:0]         r_met;
    logic [AW-1:0]         r_best;
    t_dst                  r_dst;
    logic [THW-1:0]        r_thr;
    logic [2*THW-1:0]      r_thsq;
    logic [OUT_W-1:0]      r_out_data;
    logic                  r_out_last;

    logic signed [CW-1:0]  w_in [4];
    logic [TAG_BITS-1:0]   w_in_tag;
    logic [CIW-1:0]        w_phys;
    logic signed [CW-1:0]  w_rd [3];
    logic signed [CW-1:0]  w_rd_dep;
    logic [TAG_BITS-1:0]   w_rd_tag;
    logic signed [DW-1:0]  w_diff [3];
    logic signed [OPW-1:0] w_opv [NOPD];
    logic                  w_mac_done;
    logic signed [AW-1:0]  w_acc;
    logic [AW-1:0]         w_acc_abs;
    logic [3:0]            w_psum;
    logic [TAG_BITS-1:0]   w_stag;
    logic [TAG_BITS-1:0]   w_ctag;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_in[i] = i_in_data[i*CW +: CW];
        end
    end
    assign w_in_tag = i_in_data[4*CW +: TAG_BITS];

    // candidate 4 is the new contact, held in the free entry
    assign w_phys   = (i_cmd.rd_cand == CIW'(SLOTS)) ? r_free : r_map[i_cmd.rd_cand[1:0]];
    assign w_rd[0]  = r_px[w_phys];
    assign w_rd[1]  = r_py[w_phys];
    assign w_rd[2]  = r_pz[w_phys];
    assign w_rd_dep = r_dep[w_phys];
    assign w_rd_tag = r_tag[w_phys];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_diff[i] = {w_rd[i][CW-1], w_rd[i]} - {r_base[i][CW-1], r_base[i]};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_opv[OPD_DX + i]  = OPW'(r_d[i]);
            w_opv[OPD_E1X + i] = OPW'(r_e1[i]);
            w_opv[OPD_E2X + i] = OPW'(r_e2[i]);
            w_opv[OPD_C0 + i]  = r_cr[i];
        end
    end

    cmsm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.mac_go),
        .i_a     (w_opv[i_cmd.mop.a]),
        .i_b     (w_opv[i_cmd.mop.b]),
        .i_clr   (i_cmd.mop.clr),
        .i_sub   (i_cmd.mop.sub),
        .o_done  (w_mac_done),
        .o_acc   (w_acc)
    );

    assign w_acc_abs = w_acc[AW-1] ? AW'(-w_acc) : AW'(w_acc);
    assign w_psum    = 4'(r_nmap[0]) + 4'(r_nmap[1]) + 4'(r_nmap[2]) + 4'(w_phys);
    assign w_stag    = (i_cmd.out_kind == OC_REDUCE) ? w_rd_tag : r_in_tag;
    assign w_ctag    = (i_cmd.out_kind == OC_REPLACE) ? w_rd_tag : '0;

    // slot map, threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_map[i] <= CIW'(i);
            end
            r_free <= CIW'(SLOTS);
            r_thr  <= THR_RESET;
            r_thsq <= THSQ_RESET;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            r_thsq <= {{THW{1'b0}}, r_thr} * {{THW{1'b0}}, r_thr};
            if (i_cmd.swap) begin
                r_map[i_cmd.out_idx] <= r_free;
                r_free               <= r_map[i_cmd.out_idx];
            end
            if (i_cmd.out_load && i_cmd.out_kind == OC_REDUCE && i_cmd.out_last) begin
                for (int i = 0; i < SLOTS - 1; i++) begin
                    r_map[i] <= r_nmap[i];
                end
                r_map[SLOTS-1] <= w_phys;
                r_free         <= CIW'(4'(IDX_SUM) - w_psum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_px[r_free]  <= w_in[0];
            r_py[r_free]  <= w_in[1];
            r_pz[r_free]  <= w_in[2];
            r_dep[r_free] <= w_in[3];
            r_tag[r_free] <= w_in_tag;
            r_in_tag      <= w_in_tag;
            for (int i = 0; i < 3; i++) begin
                r_base[i] <= w_in[i];
            end
        end
        if (i_cmd.ld_base) begin
            for (int i = 0; i < 3; i++) begin
                r_base[i] <= w_rd[i];
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (i_cmd.ld_diff) r_d[i]  <= w_diff[i];
            if (i_cmd.ld_e01)  r_e1[i] <= w_diff[i];
            if (i_cmd.ld_e02)  r_e2[i] <= w_diff[i];
        end
        // depth as an order-preserving unsigned key
        if (i_cmd.ld_depth) begin
            r_met <= AW'({~w_rd_dep[CW-1], w_rd_dep[CW-2:0]});
        end
        if (i_cmd.mac_go) begin
            r_dst <= i_cmd.mop.dst;
        end
        if (w_mac_done) begin
            unique case (r_dst)
                DST_CR0: r_cr[0] <= w_acc[OPW-1:0];
                DST_CR1: r_cr[1] <= w_acc[OPW-1:0];
                DST_CR2: r_cr[2] <= w_acc[OPW-1:0];
                DST_MET: r_met   <= w_acc_abs;
                default: ;
            endcase
        end
        if (i_cmd.take_best) begin
            r_best <= r_met;
        end
        if (i_cmd.out_load) begin
            if (i_cmd.out_kind == OC_REDUCE && !i_cmd.out_last) begin
                r_nmap[i_cmd.out_idx] <= w_phys;
            end
            r_out_data <= OUT_W'({i_cmd.out_cnt, (i_cmd.out_kind == OC_REPLACE), w_ctag,
                                  w_stag, i_cmd.out_idx, i_cmd.out_kind});
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_sts.mac_done = w_mac_done;
    assign o_sts.met_lt   = r_met < r_best;
    assign o_sts.met_gt   = r_met > r_best;
    assign o_sts.le_th    = r_best <= AW'(r_thsq);

    assign o_out_data = r_out_data;
    assign o_out_last = r_out_last;

endmodule

FILE: sv/cmsm_ctrl.sv
module cmsm_ctrl
    import cmsm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    input  t_dp_sts  i_sts,
    output t_dp_cmd  o_cmd,
    output logic [2:0] o_occ
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_GO, S_WAIT, S_DEEP, S_EVAL, S_PHEND, S_REP, S_INS, S_ROUT
    } t_state;

    typedef enum logic [2:0] {
        PH_MATCH, PH_DEEP, PH_FAR, PH_AREA, PH_VOL
    } t_phase;

    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    logic [CIW-1:0]  r_c, n_c;
    logic [PCW-1:0]  r_pc, n_pc;
    logic            r_first, n_first;
    logic [CIW-1:0]  r_bidx, n_bidx;
    logic [CANDS-1:0] r_used, n_used;
    logic [CIW-1:0]  r_sel [SLOTS];
    logic [CIW-1:0]  n_sel [SLOTS];
    logic [1:0]      r_k, n_k;
    logic [2:0]      r_occ, n_occ;
    logic            r_out_valid, n_out_valid;

    logic            w_out_free;
    logic            w_better;
    logic [CIW-1:0]  w_lim;
    logic [CIW-1:0]  w_next;
    logic [CANDS-1:0] w_used_b;
    logic [PCW-1:0]  w_pstart;
    logic [PCW-1:0]  w_pend;

    // lowest unused candidate at or above start, CANDS if none
    function automatic logic [CIW-1:0] nxt(input logic [CIW-1:0] start,
                                           input logic [CANDS-1:0] used);
        logic [CIW-1:0] r;
        r = CIW'(CANDS);
        for (int i = CANDS - 1; i >= 0; i--) begin
            if (CIW'(i) >= start && !used[i]) r = CIW'(i);
        end
        return r;
    endfunction

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_lim      = (r_phase == PH_MATCH) ? r_occ : CIW'(CANDS);
    assign w_next     = nxt(r_c + 1'b1, r_used);
    assign w_used_b   = r_used | (CANDS'(1) << r_bidx);
    assign w_better   = r_first || ((r_phase == PH_MATCH) ? i_sts.met_lt : i_sts.met_gt);

    always_comb begin
        unique case (r_phase)
            PH_AREA: begin w_pstart = PC_AREA; w_pend = PC_AREA_END; end
            PH_VOL:  begin w_pstart = PC_VOL;  w_pend = PC_VOL_END;  end
            default: begin w_pstart = PC_DIST; w_pend = PC_DIST_END; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_c     = r_c;
        n_pc    = r_pc;
        n_first = r_first;
        n_bidx  = r_bidx;
        n_used  = r_used;
        n_sel   = r_sel;
        n_k     = r_k;
        n_occ   = r_occ;
        n_out_valid = (r_out_valid && i_out_ready) ? 1'b0 : r_out_valid;
        o_cmd   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    if (r_occ == '0) begin
                        n_state = S_INS;
                    end else begin
                        n_phase = PH_MATCH;
                        n_c     = '0;
                        n_first = 1'b1;
                        n_used  = '0;
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.rd_cand = r_c;
                o_cmd.ld_diff = 1'b1;
                n_pc          = w_pstart;
                n_state       = S_GO;
            end
            S_GO: begin
                o_cmd.mac_go = 1'b1;
                o_cmd.mop    = mop_rom(r_pc);
                n_state      = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.mac_done) begin
                    if (r_pc == w_pend) begin
                        n_state = S_EVAL;
                    end else begin
                        n_pc    = r_pc + 1'b1;
                        n_state = S_GO;
                    end
                end
            end
            S_DEEP: begin
                o_cmd.rd_cand  = r_c;
                o_cmd.ld_depth = 1'b1;
                n_state        = S_EVAL;
            end
            S_EVAL: begin
                if (w_better) begin
                    o_cmd.take_best = 1'b1;
                    n_bidx          = r_c;
                    n_first         = 1'b0;
                end
                if (w_next < w_lim) begin
                    n_c     = w_next;
                    n_state = (r_phase == PH_DEEP) ? S_DEEP : S_LOAD;
                end else begin
                    n_state = S_PHEND;
                end
            end
            S_PHEND: begin
                o_cmd.rd_cand = r_bidx;
                n_first       = 1'b1;
                unique case (r_phase)
                    PH_MATCH: begin
                        if (i_sts.le_th) begin
                            n_state = S_REP;
                        end else if (r_occ < 3'(SLOTS)) begin
                            n_state = S_INS;
                        end else begin
                            n_phase = PH_DEEP;
                            n_c     = '0;
                            n_used  = '0;
                            n_state = S_DEEP;
                        end
                    end
                    PH_DEEP: begin
                        n_sel[0]      = r_bidx;
                        n_used        = w_used_b;
                        o_cmd.ld_base = 1'b1;
                        n_phase       = PH_FAR;
                        n_c           = nxt('0, w_used_b);
                        n_state       = S_LOAD;
                    end
                    PH_FAR: begin
                        n_sel[1]     = r_bidx;
                        n_used       = w_used_b;
                        o_cmd.ld_e01 = 1'b1;
                        n_phase      = PH_AREA;
                        n_c          = nxt('0, w_used_b);
                        n_state      = S_LOAD;
                    end
                    PH_AREA: begin
                        n_sel[2]     = r_bidx;
                        n_used       = w_used_b;
                        o_cmd.ld_e02 = 1'b1;
                        n_phase      = PH_VOL;
                        n_c          = nxt('0, w_used_b);
                        n_state      = S_LOAD;
                    end
                    default: begin
                        n_sel[3] = r_bidx;
                        n_k      = '0;
                        n_state  = S_ROUT;
                    end
                endcase
            end
            S_REP: begin
                if (w_out_free) begin
                    o_cmd.rd_cand  = r_bidx;
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = OC_REPLACE;
                    o_cmd.out_idx  = r_bidx[1:0];
                    o_cmd.out_cnt  = r_occ;
                    o_cmd.out_last = 1'b1;
                    o_cmd.swap     = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_INS: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = OC_INSERT;
                    o_cmd.out_idx  = r_occ[1:0];
                    o_cmd.out_cnt  = r_occ + 1'b1;
                    o_cmd.out_last = 1'b1;
                    o_cmd.swap     = 1'b1;
                    n_occ          = r_occ + 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_ROUT: begin
                if (w_out_free) begin
                    o_cmd.rd_cand  = r_sel[r_k];
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = OC_REDUCE;
                    o_cmd.out_idx  = r_k;
                    o_cmd.out_cnt  = 3'(SLOTS);
                    o_cmd.out_last = (r_k == 2'(SLOTS - 1));
                    n_out_valid    = 1'b1;
                    n_k            = r_k + 1'b1;
                    if (r_k == 2'(SLOTS - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_MATCH;
            r_c         <= '0;
            r_pc        <= '0;
            r_first     <= 1'b1;
            r_bidx      <= '0;
            r_used      <= '0;
            r_k         <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_sel[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_c         <= n_c;
            r_pc        <= n_pc;
            r_first     <= n_first;
            r_bidx      <= n_bidx;
            r_used      <= n_used;
            r_sel       <= n_sel;
            r_k         <= n_k;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_occ       = r_occ;

endmodule

FILE: sv/contact_manifold_slot_manager_top.sv
// Channel     Direction  Handshake                          Payload
// s_axis      in         i_s_axis_tvalid / o_s_axis_tready  x, y, z, depth, tag
// m_axis      out        o_m_axis_tvalid / i_m_axis_tready  one slot result, tlast on final
// cfg         in         i_cfg_wr_en                        match_threshold
//
// Matching runs one squared distance per occupied slot: each squared distance is three
// products on one shared 68x17-bit multiplier.
// A reduction (manifold full, no match) runs a match pass, depth scan, distance
// pass, area pass (nine products per candidate) and volume pass.
// Reset (synchronous, active low) empties the manifold and restores threshold 1311.
// A result waits in the output register; the next contact is accepted meanwhile,
// but the block stalls before loading a new result until the old one is taken.
module contact_manifold_slot_manager_top
    import cmsm_pkg::*;
#(
    parameter int TAG_BITS = 16,
    localparam int IN_W  = ((4 * CW + TAG_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((8 + 2 * TAG_BITS + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // point_x, point_y, point_z, pen_depth, payload_tag
    input  logic [IN_W-1:0]   i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // outcome, slot_index, slot_tag, carried_tag, carried_valid, slot_count
    output logic [OUT_W-1:0]  o_m_axis_tdata,
    output logic              o_m_axis_tlast,
    input  logic              i_cfg_wr_en,
    input  logic [THW-1:0]    i_cfg_wr_data
);

    localparam int CV_BIT  = 4 + 2 * TAG_BITS;
    localparam int CNT_LSB = CV_BIT + 1;

    t_dp_cmd    w_cmd;
    t_dp_sts    w_sts;
    logic [2:0] w_occ;

    // sequencer: match scan, reduction passes, result emission
    cmsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_occ       (w_occ)
    );

    // slot store with indirection map, multiplier, metric compare, output register
    cmsm_dp #(
        .TAG_BITS (TAG_BITS),
        .IN_W     (IN_W),
        .OUT_W    (OUT_W)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_s_axis_tdata),
        .i_cfg_we   (i_cfg_wr_en),
        .i_cfg_data (i_cfg_wr_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_data (o_m_axis_tdata),
        .o_out_last (o_m_axis_tlast)
    );

    // a transfer in always takes the block busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while busy");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[1:0] == OC_REDUCE)
            |-> (o_m_axis_tdata[CNT_LSB +: 3] == 3'(SLOTS)))
        else $error("reduction result with partial count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[CV_BIT])
            |-> (o_m_axis_tdata[1:0] == OC_REPLACE && o_m_axis_tlast))
        else $error("carried tag outside a replace");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_occ <= 3'(SLOTS))
        else $error("occupancy overflow");

endmodule

FILE: verif/manifold_checker.sv
module manifold_checker
    import cmsm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_valid,
    input  logic            s_ready,
    input  logic [143:0]    s_data,
    input  logic            m_valid,
    input  logic            m_ready,
    input  logic [39:0]     m_data,
    input  logic            m_last,
    input  logic            cfg_wr_en,
    input  logic [THW-1:0]  cfg_wr_data,
    output int              fail_count,
    output int              pending
);

    // wide enough for every product of the selection passes
    typedef logic signed [191:0] t_wide;

    typedef struct {
        t_outcome    kind;
        logic [1:0]  idx;
        logic [15:0] tag;
        logic [15:0] ctag;
        logic        cv;
        logic [2:0]  cnt;
        logic        last;
    } t_slot_result;

    t_slot_result   exp_slots[$];
    t_slot_result   head;
    t_wide          spx[4], spy[4], spz[4], sdp[4];
    logic [15:0]    stag[4];
    int             occ;
    logic [THW-1:0] thr;

    initial begin
        fail_count = 0;
        pending    = 0;
        occ        = 0;
        thr        = THR_RESET;
    end

    function automatic t_wide dist2(t_wide ax, t_wide ay, t_wide az,
                                    t_wide bx, t_wide by, t_wide bz);
        t_wide dx, dy, dz;
        dx = ax - bx;
        dy = ay - by;
        dz = az - bz;
        return dx * dx + dy * dy + dz * dz;
    endfunction

    task automatic push_result(t_outcome k, int idx, logic [15:0] tg, logic [15:0] ctg,
                               logic cv, int cnt, logic last);
        t_slot_result r;
        r.kind = k;
        r.idx  = idx[1:0];
        r.tag  = tg;
        r.ctag = ctg;
        r.cv   = cv;
        r.cnt  = cnt[2:0];
        r.last = last;
        exp_slots.insert(exp_slots.size(), r);
    endtask

    task automatic predict_contact(input logic [143:0] d);
        t_wide       px, py, pz, dp, bd, dd, bv, v, thsq;
        t_wide       cx[5], cy[5], cz[5], cd[5];
        t_wide       e1[3], e2[3], ec[3], cr[3];
        logic [15:0] tg;
        logic [15:0] ct[5];
        bit          used[5];
        int          sel[4];
        int          best;
        px = t_wide'($signed(d[31:0]));
        py = t_wide'($signed(d[63:32]));
        pz = t_wide'($signed(d[95:64]));
        dp = t_wide'($signed(d[127:96]));
        tg = d[143:128];
        thsq = $signed({161'b0, thr}) * $signed({161'b0, thr});

        // nearest occupied slot, first index wins ties
        if (occ > 0) begin
            best = 0;
            bd = dist2(spx[0], spy[0], spz[0], px, py, pz);
            for (int i = 1; i < occ; i++) begin
                dd = dist2(spx[i], spy[i], spz[i], px, py, pz);
                if (dd < bd) begin
                    bd = dd;
                    best = i;
                end
            end
            if (bd <= thsq) begin
                push_result(OC_REPLACE, best, tg, stag[best], 1'b1, occ, 1'b1);
                spx[best] = px; spy[best] = py; spz[best] = pz;
                sdp[best] = dp; stag[best] = tg;
                return;
            end
        end

        if (occ < 4) begin
            spx[occ] = px; spy[occ] = py; spz[occ] = pz;
            sdp[occ] = dp; stag[occ] = tg;
            occ++;
            push_result(OC_INSERT, occ - 1, tg, 16'h0, 1'b0, occ, 1'b1);
            return;
        end

        // full: pick four of five candidates
        for (int c = 0; c < 4; c++) begin
            cx[c] = spx[c]; cy[c] = spy[c]; cz[c] = spz[c];
            cd[c] = sdp[c]; ct[c] = stag[c];
            used[c] = 0;
        end
        cx[4] = px; cy[4] = py; cz[4] = pz; cd[4] = dp; ct[4] = tg; used[4] = 0;

        sel[0] = 0;
        for (int c = 1; c < 5; c++)
            if (cd[c] > cd[sel[0]]) sel[0] = c;
        used[sel[0]] = 1;

        sel[1] = -1;
        for (int c = 0; c < 5; c++) begin
            if (!used[c]) begin
                v = dist2(cx[c], cy[c], cz[c], cx[sel[0]], cy[sel[0]], cz[sel[0]]);
                if (sel[1] < 0 || v > bv) begin
                    bv = v;
                    sel[1] = c;
                end
            end
        end
        used[sel[1]] = 1;

        e1[0] = cx[sel[1]] - cx[sel[0]];
        e1[1] = cy[sel[1]] - cy[sel[0]];
        e1[2] = cz[sel[1]] - cz[sel[0]];
        sel[2] = -1;
        for (int c = 0; c < 5; c++) begin
            if (!used[c]) begin
                ec[0] = cx[c] - cx[sel[0]];
                ec[1] = cy[c] - cy[sel[0]];
                ec[2] = cz[c] - cz[sel[0]];
                cr[0] = e1[1] * ec[2] - e1[2] * ec[1];
                cr[1] = e1[2] * ec[0] - e1[0] * ec[2];
                cr[2] = e1[0] * ec[1] - e1[1] * ec[0];
                v = cr[0] * cr[0] + cr[1] * cr[1] + cr[2] * cr[2];
                if (sel[2] < 0 || v > bv) begin
                    bv = v;
                    sel[2] = c;
                end
            end
        end
        used[sel[2]] = 1;

        e2[0] = cx[sel[2]] - cx[sel[0]];
        e2[1] = cy[sel[2]] - cy[sel[0]];
        e2[2] = cz[sel[2]] - cz[sel[0]];
        sel[3] = -1;
        for (int c = 0; c < 5; c++) begin
            if (!used[c]) begin
                ec[0] = cx[c] - cx[sel[0]];
                ec[1] = cy[c] - cy[sel[0]];
                ec[2] = cz[c] - cz[sel[0]];
                cr[0] = e2[1] * ec[2] - e2[2] * ec[1];
                cr[1] = e2[2] * ec[0] - e2[0] * ec[2];
                cr[2] = e2[0] * ec[1] - e2[1] * ec[0];
                v = e1[0] * cr[0] + e1[1] * cr[1] + e1[2] * cr[2];
                if (v < 0) v = -v;
                if (sel[3] < 0 || v > bv) begin
                    bv = v;
                    sel[3] = c;
                end
            end
        end

        for (int k = 0; k < 4; k++) begin
            spx[k] = cx[sel[k]]; spy[k] = cy[sel[k]]; spz[k] = cz[sel[k]];
            sdp[k] = cd[sel[k]]; stag[k] = ct[sel[k]];
            push_result(OC_REDUCE, k, ct[sel[k]], 16'h0, 1'b0, 4, k == 3);
        end
    endtask

    task automatic check_field(string name, longint expv, longint act);
        if (expv != act) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, act);
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            thr = THR_RESET;
            occ = 0;
            exp_slots.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (exp_slots.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_data);
                end else begin
                    head = exp_slots.pop_front();
                    check_field("outcome", head.kind, m_data[1:0]);
                    check_field("slot_index", head.idx, m_data[3:2]);
                    check_field("slot_tag", head.tag, m_data[19:4]);
                    check_field("carried_tag", head.ctag, m_data[35:20]);
                    check_field("carried_valid", head.cv, m_data[36]);
                    check_field("slot_count", head.cnt, m_data[39:37]);
                    check_field("last", head.last, m_last);
                end
            end
            if (s_valid && s_ready) predict_contact(s_data);
            if (cfg_wr_en) thr = cfg_wr_data;
        end
        pending = exp_slots.size();
    end

endmodule

FILE: verif/tb.sv
module tb;
    import cmsm_pkg::*;

    localparam int STALL_LIMIT = 20000;   // cycles without any transfer
    localparam int SETTLE      = 700;     // longer than a full reduction

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    logic [143:0]   s_data = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    logic [39:0]    m_data;
    logic           m_last;
    logic           cfg_wr_en = 1'b0;
    logic [THW-1:0] cfg_wr_data = '0;
    int             fail_count;
    int             pending;
    int             quiet_cycles = 0;
    bit             idle_on = 1'b1;     // random gaps on both sides
    logic [31:0]    base_pt[6][3];      // cluster centers for well-formed sequences

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    contact_manifold_slot_manager_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        // point_x, point_y, point_z, pen_depth, payload_tag
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // outcome, slot_index, slot_tag, carried_tag, carried_valid, slot_count
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    manifold_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .m_last      (m_last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // receiver: stalls about 36% of cycles while idling is on
    always @(posedge clk)
        m_ready <= !idle_on || ($urandom_range(99) >= 36);

    // watchdog: any transfer restarts the count
    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // one contact transfer; tvalid stays high into the next call unless a gap is drawn
    task automatic send_contact(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                logic [31:0] dp, logic [15:0] tg);
        while (idle_on && $urandom_range(99) < 36) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {tg, dp, z, y, x};
        do @(posedge clk); while (!s_ready);
    endtask

    // random contact: mostly clustered so that matches and reductions both happen
    task automatic send_random();
        int          b;
        logic [31:0] p[3];
        logic [31:0] dp;
        b = $urandom_range(5);
        for (int a = 0; a < 3; a++)
            p[a] = base_pt[b][a] + $urandom_range(6000) - 3000;
        dp = $urandom_range(200000) - 100000;
        if ($urandom_range(9) < 2) begin
            for (int a = 0; a < 3; a++) p[a] = $urandom;
            dp = $urandom;
        end
        send_contact(p[0], p[1], p[2], dp, 16'($urandom_range(16'hFFFF)));
    endtask

    // stop sending, let every expected result arrive, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_threshold(logic [THW-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [THW-1:0] thr_list[5];
        thr_list = '{31'd0, 31'h7FFF_FFFF, 31'd3000, THR_RESET, 31'd100000};
        for (int b = 0; b < 6; b++)
            for (int a = 0; a < 3; a++)
                base_pt[b][a] = $urandom_range(4000000) - 2000000;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset threshold: empty insert, exact and boundary matches
        send_contact(32'd0, 32'd0, 32'd0, 32'd0, 16'h0000);
        send_contact(32'd0, 32'd0, 32'd0, 32'd5, 16'h0001);
        send_contact(32'd1311, 32'd0, 32'd0, 32'd7, 16'h0002);       // distance equals threshold
        send_contact(32'd2623, 32'd0, 32'd0, 32'd7, 16'h0003);       // one past: insert
        send_contact(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
        send_contact(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000);
        // manifold full from here: reductions
        send_contact(32'd1000000, -32'sd1000000, 32'd5, 32'd10, 16'h1234);
        send_contact(-32'sd5000000, 32'd3, 32'd3, 32'h7FFF_FFFF, 16'h5678);   // tie on depth
        // collinear and coincident points: zero area and volume ties
        for (int k = 0; k < 5; k++)
            send_contact(32'd5000000 + 32'd1000000 * k, 32'd0, 32'd0, 32'd100,
                         16'(16'h0A00 + k));
        send_contact(32'd9000000, 32'd0, 32'd0, 32'd100, 16'h0B00);
        send_contact(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'hAAAA);
        send_contact(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, -32'sd1, 16'h5555);

        // random phases, threshold rewritten only when the block is idle
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            write_threshold(thr_list[ph]);
            for (int n = 0; n < 89; n++) begin
                idle_on = !(ph == 2 && n >= 20 && n < 70);   // gap-free stretch
                send_random();
            end
        end
        idle_on = 1'b1;

        drain();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/cmsm_pkg.sv
sv/cmsm_mac.sv
sv/cmsm_dp.sv
sv/cmsm_ctrl.sv
sv/contact_manifold_slot_manager_top.sv
verif/manifold_checker.sv
verif/tb.sv
